// ----- design/rwc_pkg.sv -----
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared sizes, register map, codes and step tables of the wall simulator.
// ----------------------------------------------------------------------------
package rwc_pkg;

  localparam int GRID_W    = 100;
  localparam int GRID_H    = 40;
  localparam int CHAIN_LEN = 100;
  localparam int HIT_BITS  = 32;
  localparam int CELLS     = GRID_W * GRID_H;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int PT_AW     = 7;
  localparam int X_W       = 7;
  localparam int Y_W       = 6;
  localparam int OWN_W     = 8;
  localparam int PERIOD_W  = 20;
  localparam int C_W       = 9;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam int RESET_SOURCE = 50;
  localparam int RESET_CENTER = 10;
  localparam int RESET_PERIOD = 10000;
  localparam int INIT_X0      = RESET_SOURCE - CHAIN_LEN / 4;
  localparam int TURN_RIGHT   = CHAIN_LEN / 4;
  localparam int TURN_UP      = 3 * CHAIN_LEN / 4 - 2;

  localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_CENTER = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic CMD_WALK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic signed [C_W-1:0] coord_t;

  localparam coord_t STEP_DX [4] = '{coord_t'(0), coord_t'(1), coord_t'(0), -coord_t'(1)};
  localparam coord_t STEP_DY [4] = '{-coord_t'(1), coord_t'(0), coord_t'(1), coord_t'(0)};
  localparam coord_t MOVE_DX [8] = '{coord_t'(0), coord_t'(1), coord_t'(1), coord_t'(1),
                                     coord_t'(0), -coord_t'(1), -coord_t'(1), -coord_t'(1)};
  localparam coord_t MOVE_DY [8] = '{-coord_t'(1), -coord_t'(1), coord_t'(0), coord_t'(1),
                                     coord_t'(1), coord_t'(1), coord_t'(0), -coord_t'(1)};

  function automatic logic on_grid(coord_t x, coord_t y);
    return x >= 0 && x < coord_t'(GRID_W) && y >= 0 && y < coord_t'(GRID_H);
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(coord_t x, coord_t y);
    int a;
    a = int'(y) * GRID_W + int'(x);
    return a[CELL_AW-1:0];
  endfunction

  function automatic logic adjacent8(coord_t x, coord_t y, coord_t tx, coord_t ty);
    coord_t ddx;
    coord_t ddy;
    ddx = x - tx;
    ddy = y - ty;
    return ddx >= -coord_t'(1) && ddx <= coord_t'(1) && ddy >= -coord_t'(1) &&
           ddy <= coord_t'(1);
  endfunction

endpackage

// ----- design/rwc_ram.sv -----
// ----------------------------------------------------------------------------
// rwc_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rwc_ram #(
  parameter  int DEPTH = 2,
  parameter  int WIDTH = 1,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/random_walk_chain_wall_sim.sv -----
// ----------------------------------------------------------------------------
// random_walk_chain_wall_sim
// Walker step engine with chain-wall impacts and periodic chain point moves.
//
//   channel | ports                        | direction
//   --------+------------------------------+----------
//   input   | in_valid/in_ready, in_*      | in
//   result  | out_valid/out_ready, out_*   | out
//   config  | psel/penable/pwrite/paddr... | in/out
//
// Each RAM has one registered read port, so the sequencer reads the chain and
// occupancy RAMs one address per state.
// After reset the block clears the occupancy RAM and lays out the chain with
// in_ready low; config writes are taken meanwhile.
// A finished result sits in the output register; the next transfer may
// start while it waits.
// ----------------------------------------------------------------------------
module random_walk_chain_wall_sim (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rwc_pkg::ADDR_W-1:0]    paddr,
  input  logic [rwc_pkg::DATA_W-1:0]    pwdata,
  output logic [rwc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [1:0]                    in_walk_dir,
  input  logic [rwc_pkg::PT_AW-1:0]     in_point_index,
  input  logic [2:0]                    in_point_move,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rwc_pkg::X_W-1:0]       out_walker_col,
  output logic [rwc_pkg::Y_W-1:0]       out_walker_row,
  output logic                          out_wall_hit,
  output logic [rwc_pkg::PT_AW-1:0]     out_hit_point,
  output logic                          out_off_grid,
  output logic                          out_tweak_tried,
  output logic                          out_tweak_taken,
  output logic [rwc_pkg::X_W-1:0]       out_point_col,
  output logic [rwc_pkg::Y_W-1:0]       out_point_row,
  output logic [rwc_pkg::HIT_BITS-1:0]  out_point_hits
);

  typedef enum logic [14:0] {
    ST_INIT_CLR = 15'h0001,
    ST_INIT_CHN = 15'h0002,
    ST_IDLE     = 15'h0004,
    ST_RD_WAIT  = 15'h0008,
    ST_WALK     = 15'h0010,
    ST_WALK_OWN = 15'h0020,
    ST_WALK_HIT = 15'h0040,
    ST_PHASE    = 15'h0080,
    ST_TWK_PT   = 15'h0100,
    ST_TWK_LO   = 15'h0200,
    ST_TWK_HI   = 15'h0400,
    ST_TWK_NEW  = 15'h0800,
    ST_TWK_OLD  = 15'h1000,
    ST_TWK_WR   = 15'h2000,
    ST_DONE     = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [rwc_pkg::X_W-1:0]      src_x_r;
  logic [rwc_pkg::Y_W-1:0]      ctr_r;
  logic [rwc_pkg::PERIOD_W-1:0] period_r;
  logic [rwc_pkg::X_W-1:0]      wx_r;
  logic [rwc_pkg::Y_W-1:0]      wy_r;
  logic [rwc_pkg::PERIOD_W-1:0] phase_r;
  logic [rwc_pkg::CELL_AW-1:0]  clr_cnt_r;
  logic [rwc_pkg::PT_AW-1:0]    ini_i_r;
  rwc_pkg::coord_t              ini_x_r, ini_y_r;

  logic [1:0]                   dir_r;
  logic [rwc_pkg::PT_AW-1:0]    idx_r;
  logic [2:0]                   mv_r;
  logic                         res_wall_r, res_off_r, res_tried_r, res_taken_r;
  logic [rwc_pkg::PT_AW-1:0]    res_hitp_r;
  logic [rwc_pkg::X_W-1:0]      res_pc_r;
  logic [rwc_pkg::Y_W-1:0]      res_pr_r;
  logic [rwc_pkg::HIT_BITS-1:0] res_ph_r;
  rwc_pkg::coord_t              cand_x_r, cand_y_r;
  rwc_pkg::coord_t              ox_r, oy_r, lx_r, ly_r, hx_r, hy_r, nx_r, ny_r;
  logic [rwc_pkg::HIT_BITS-1:0] h_r, a_r, b_r, avg_r;
  logic                         legal_r;

  logic                         out_valid_r;
  logic [rwc_pkg::X_W-1:0]      out_wc_r;
  logic [rwc_pkg::Y_W-1:0]      out_wr_r;
  logic                         out_wall_r, out_off_r, out_tried_r, out_taken_r;
  logic [rwc_pkg::PT_AW-1:0]    out_hitp_r;
  logic [rwc_pkg::X_W-1:0]      out_pc_r;
  logic [rwc_pkg::Y_W-1:0]      out_pr_r;
  logic [rwc_pkg::HIT_BITS-1:0] out_ph_r;

  // RAM ports
  logic                         own_we;
  logic [rwc_pkg::CELL_AW-1:0]  own_waddr, own_raddr;
  logic [rwc_pkg::OWN_W-1:0]    own_wdata, own_rdata;
  logic                         pt_we, hit_we;
  logic [rwc_pkg::PT_AW-1:0]    pt_waddr, hit_waddr, pt_raddr;
  logic [rwc_pkg::X_W-1:0]      px_wdata, px_rdata;
  logic [rwc_pkg::Y_W-1:0]      py_wdata, py_rdata;
  logic [rwc_pkg::HIT_BITS-1:0] hit_wdata, hit_rdata;

  rwc_ram #(.DEPTH(rwc_pkg::CELLS), .WIDTH(rwc_pkg::OWN_W)) u_owner (
    .clk, .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rdata)
  );
  rwc_ram #(.DEPTH(rwc_pkg::CHAIN_LEN), .WIDTH(rwc_pkg::X_W)) u_px (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(px_wdata),
    .raddr(pt_raddr), .rdata(px_rdata)
  );
  rwc_ram #(.DEPTH(rwc_pkg::CHAIN_LEN), .WIDTH(rwc_pkg::Y_W)) u_py (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(py_wdata),
    .raddr(pt_raddr), .rdata(py_rdata)
  );
  rwc_ram #(.DEPTH(rwc_pkg::CHAIN_LEN), .WIDTH(rwc_pkg::HIT_BITS)) u_hits (
    .clk, .we(hit_we), .waddr(hit_waddr), .wdata(hit_wdata),
    .raddr(pt_raddr), .rdata(hit_rdata)
  );

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      rwc_pkg::REG_SOURCE: prdata = rwc_pkg::DATA_W'(src_x_r);
      rwc_pkg::REG_CENTER: prdata = rwc_pkg::DATA_W'(ctr_r);
      rwc_pkg::REG_PERIOD: prdata = rwc_pkg::DATA_W'(period_r);
      default:             prdata = '0;
    endcase
  end

  // combinational helpers
  rwc_pkg::coord_t sx, cy, wnx, wny, tnx, tny;
  logic            has_lo, has_hi, idx_ok, tw_due;
  logic            own_hit, new_legal, tk_agree;
  logic [rwc_pkg::PT_AW-1:0]    own_p;
  logic [rwc_pkg::PERIOD_W-1:0] eff_period;
  logic signed [rwc_pkg::C_W+1:0] rdx, rdy, rd;
  logic [rwc_pkg::HIT_BITS:0]   nb_sum, two_h;
  logic                         lap_pos, lap_neg;
  logic [rwc_pkg::HIT_BITS-1:0] avg_v, hit_inc;

  assign sx      = rwc_pkg::coord_t'({2'b00, src_x_r});
  assign cy      = rwc_pkg::coord_t'({3'b000, ctr_r});
  assign wnx     = rwc_pkg::coord_t'({2'b00, wx_r}) + rwc_pkg::STEP_DX[dir_r];
  assign wny     = rwc_pkg::coord_t'({3'b000, wy_r}) + rwc_pkg::STEP_DY[dir_r];
  assign tnx     = ox_r + rwc_pkg::MOVE_DX[mv_r];
  assign tny     = oy_r + rwc_pkg::MOVE_DY[mv_r];
  assign has_lo  = idx_r != '0;
  assign has_hi  = idx_r != rwc_pkg::PT_AW'(rwc_pkg::CHAIN_LEN - 1);
  assign idx_ok  = idx_r < rwc_pkg::PT_AW'(rwc_pkg::CHAIN_LEN);
  assign own_hit = own_rdata != '0 && own_rdata <= rwc_pkg::OWN_W'(rwc_pkg::CHAIN_LEN);
  assign own_p   = rwc_pkg::PT_AW'(own_rdata - rwc_pkg::OWN_W'(1));
  assign hit_inc = (hit_rdata == rwc_pkg::HIT_MAX) ? hit_rdata : hit_rdata + 1'b1;
  assign eff_period = (period_r == '0) ? rwc_pkg::PERIOD_W'(1) : period_r;
  assign tw_due  = phase_r >= eff_period;

  always_comb begin
    new_legal = rwc_pkg::on_grid(nx_r, ny_r) && nx_r != sx && ny_r != '0 &&
                own_rdata == '0;
    if (has_lo && !rwc_pkg::adjacent8(nx_r, ny_r, lx_r, ly_r)) new_legal = 1'b0;
    if (has_hi && !rwc_pkg::adjacent8(nx_r, ny_r, hx_r, hy_r)) new_legal = 1'b0;
    if (!has_lo && !(ny_r == oy_r && nx_r < sx)) new_legal = 1'b0;
    if (!has_hi && !(ny_r == oy_r && nx_r > sx)) new_legal = 1'b0;
  end

  // squared distance change; each coordinate moves by at most one
  always_comb begin
    logic signed [rwc_pkg::C_W+1:0] sumx, sumy;
    sumx = (rwc_pkg::C_W+2)'(nx_r) + (rwc_pkg::C_W+2)'(ox_r) - ((rwc_pkg::C_W+2)'(sx) <<< 1);
    sumy = (rwc_pkg::C_W+2)'(ny_r) + (rwc_pkg::C_W+2)'(oy_r) - ((rwc_pkg::C_W+2)'(cy) <<< 1);
    priority if (nx_r > ox_r) rdx = sumx;
    else if (nx_r < ox_r)     rdx = -sumx;
    else                      rdx = '0;
    priority if (ny_r > oy_r) rdy = sumy;
    else if (ny_r < oy_r)     rdy = -sumy;
    else                      rdy = '0;
    rd = rdx + rdy;
  end

  assign nb_sum = {1'b0, a_r} + {1'b0, b_r};
  assign two_h  = {h_r, 1'b0};

  always_comb begin
    if (has_lo && has_hi) begin
      lap_pos = two_h > nb_sum;
      lap_neg = two_h < nb_sum;
      avg_v   = nb_sum[rwc_pkg::HIT_BITS:1];
    end else if (has_lo) begin
      lap_pos = h_r > a_r;
      lap_neg = h_r < a_r;
      avg_v   = a_r;
    end else begin
      lap_pos = h_r > b_r;
      lap_neg = h_r < b_r;
      avg_v   = b_r;
    end
  end

  assign tk_agree = legal_r && ((rd > 0 && lap_pos) || (rd < 0 && lap_neg));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    own_we    = 1'b0;
    own_waddr = clr_cnt_r;
    own_wdata = '0;
    own_raddr = rwc_pkg::cell_addr(wnx, wny);
    pt_we     = 1'b0;
    pt_waddr  = ini_i_r;
    px_wdata  = rwc_pkg::X_W'(ini_x_r);
    py_wdata  = rwc_pkg::Y_W'(ini_y_r);
    hit_we    = 1'b0;
    hit_waddr = ini_i_r;
    hit_wdata = '0;
    pt_raddr  = idx_r;
    unique case (state_r)
      ST_INIT_CLR: begin
        own_we = 1'b1;
        if (clr_cnt_r == rwc_pkg::CELL_AW'(rwc_pkg::CELLS - 1)) state_nxt = ST_INIT_CHN;
      end
      ST_INIT_CHN: begin
        own_we    = rwc_pkg::on_grid(ini_x_r, ini_y_r);
        own_waddr = rwc_pkg::cell_addr(ini_x_r, ini_y_r);
        own_wdata = rwc_pkg::OWN_W'(ini_i_r) + rwc_pkg::OWN_W'(1);
        pt_we     = 1'b1;
        hit_we    = 1'b1;
        if (ini_i_r == rwc_pkg::PT_AW'(rwc_pkg::CHAIN_LEN - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        pt_raddr = in_point_index;
        if (in_valid) state_nxt = (in_command == rwc_pkg::CMD_READ) ? ST_RD_WAIT : ST_WALK;
      end
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_WALK: begin
        if (wny < 0 || !rwc_pkg::on_grid(wnx, wny)) state_nxt = ST_PHASE;
        else                                          state_nxt = ST_WALK_OWN;
      end
      ST_WALK_OWN: begin
        pt_raddr  = own_p;
        state_nxt = own_hit ? ST_WALK_HIT : ST_PHASE;
      end
      ST_WALK_HIT: begin
        hit_we    = 1'b1;
        hit_waddr = res_hitp_r;
        hit_wdata = hit_inc;
        state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        if (tw_due && idx_ok) state_nxt = ST_TWK_PT;
        else                  state_nxt = ST_DONE;
      end
      ST_TWK_PT: begin
        pt_raddr  = idx_r - 1'b1;
        state_nxt = ST_TWK_LO;
      end
      ST_TWK_LO: begin
        pt_raddr  = idx_r + 1'b1;
        state_nxt = ST_TWK_HI;
      end
      ST_TWK_HI: begin
        own_raddr = rwc_pkg::cell_addr(tnx, tny);
        state_nxt = ST_TWK_NEW;
      end
      ST_TWK_NEW: begin
        own_raddr = rwc_pkg::cell_addr(ox_r, oy_r);
        state_nxt = ST_TWK_OLD;
      end
      ST_TWK_OLD: begin
        own_waddr = rwc_pkg::cell_addr(ox_r, oy_r);
        own_we    = tk_agree && rwc_pkg::on_grid(ox_r, oy_r) &&
                    own_rdata == rwc_pkg::OWN_W'(idx_r) + rwc_pkg::OWN_W'(1);
        state_nxt = tk_agree ? ST_TWK_WR : ST_DONE;
      end
      ST_TWK_WR: begin
        own_we    = 1'b1;
        own_waddr = rwc_pkg::cell_addr(nx_r, ny_r);
        own_wdata = rwc_pkg::OWN_W'(idx_r) + rwc_pkg::OWN_W'(1);
        pt_we     = 1'b1;
        pt_waddr  = idx_r;
        px_wdata  = rwc_pkg::X_W'(nx_r);
        py_wdata  = rwc_pkg::Y_W'(ny_r);
        hit_we    = 1'b1;
        hit_waddr = idx_r;
        hit_wdata = avg_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT_CLR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT_CLR;
      src_x_r     <= rwc_pkg::X_W'(rwc_pkg::RESET_SOURCE);
      ctr_r       <= rwc_pkg::Y_W'(rwc_pkg::RESET_CENTER);
      period_r    <= rwc_pkg::PERIOD_W'(rwc_pkg::RESET_PERIOD);
      wx_r        <= rwc_pkg::X_W'(rwc_pkg::RESET_SOURCE);
      wy_r        <= '0;
      phase_r     <= '0;
      clr_cnt_r   <= '0;
      ini_i_r     <= '0;
      ini_x_r     <= rwc_pkg::coord_t'(rwc_pkg::INIT_X0);
      ini_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          rwc_pkg::REG_SOURCE: src_x_r  <= pwdata[rwc_pkg::X_W-1:0];
          rwc_pkg::REG_CENTER: ctr_r    <= pwdata[rwc_pkg::Y_W-1:0];
          rwc_pkg::REG_PERIOD: period_r <= pwdata[rwc_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_INIT_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_INIT_CHN) begin
        ini_i_r <= ini_i_r + 1'b1;
        priority if (ini_i_r >= rwc_pkg::PT_AW'(rwc_pkg::TURN_UP))
          ini_y_r <= ini_y_r - 1'b1;
        else if (ini_i_r > rwc_pkg::PT_AW'(rwc_pkg::TURN_RIGHT))
          ini_x_r <= ini_x_r + 1'b1;
        else
          ini_y_r <= ini_y_r + 1'b1;
      end
      if (state_r == ST_WALK) begin
        if (wny < 0 || !rwc_pkg::on_grid(wnx, wny)) begin
          wx_r <= src_x_r;
          wy_r <= '0;
        end
      end
      if (state_r == ST_WALK_OWN) begin
        if (own_hit) begin
          wx_r <= src_x_r;
          wy_r <= '0;
        end else begin
          wx_r <= rwc_pkg::X_W'(cand_x_r);
          wy_r <= rwc_pkg::Y_W'(cand_y_r);
        end
      end
      if (state_r == ST_PHASE) begin
        if (tw_due) begin
          phase_r <= rwc_pkg::PERIOD_W'(1);
          wx_r    <= src_x_r;
          wy_r    <= '0;
        end else begin
          phase_r <= phase_r + 1'b1;
        end
      end
      if (state_r == ST_DONE && state_nxt == ST_IDLE) out_valid_r <= 1'b1;
      else if (out_ready)                             out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        dir_r       <= in_walk_dir;
        idx_r       <= in_point_index;
        mv_r        <= in_point_move;
        res_wall_r  <= 1'b0;
        res_hitp_r  <= '0;
        res_off_r   <= 1'b0;
        res_tried_r <= 1'b0;
        res_taken_r <= 1'b0;
        res_pc_r    <= '0;
        res_pr_r    <= '0;
        res_ph_r    <= '0;
      end
      ST_RD_WAIT: begin
        if (idx_ok) begin
          res_pc_r <= px_rdata;
          res_pr_r <= py_rdata;
          res_ph_r <= hit_rdata;
        end
      end
      ST_WALK: begin
        cand_x_r <= wnx;
        cand_y_r <= wny;
        if (!(wny < 0) && !rwc_pkg::on_grid(wnx, wny)) res_off_r <= 1'b1;
      end
      ST_WALK_OWN: begin
        if (own_hit) begin
          res_wall_r <= 1'b1;
          res_hitp_r <= own_p;
        end
      end
      ST_PHASE: begin
        if (tw_due) res_tried_r <= 1'b1;
      end
      ST_TWK_PT: begin
        ox_r <= rwc_pkg::coord_t'({2'b00, px_rdata});
        oy_r <= rwc_pkg::coord_t'({3'b000, py_rdata});
        h_r  <= hit_rdata;
      end
      ST_TWK_LO: begin
        lx_r <= rwc_pkg::coord_t'({2'b00, px_rdata});
        ly_r <= rwc_pkg::coord_t'({3'b000, py_rdata});
        a_r  <= hit_rdata;
      end
      ST_TWK_HI: begin
        hx_r <= rwc_pkg::coord_t'({2'b00, px_rdata});
        hy_r <= rwc_pkg::coord_t'({3'b000, py_rdata});
        b_r  <= hit_rdata;
        nx_r <= tnx;
        ny_r <= tny;
      end
      ST_TWK_NEW: legal_r <= new_legal;
      ST_TWK_OLD: avg_r   <= avg_v;
      ST_TWK_WR:  res_taken_r <= 1'b1;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_wc_r    <= wx_r;
          out_wr_r    <= wy_r;
          out_wall_r  <= res_wall_r;
          out_hitp_r  <= res_hitp_r;
          out_off_r   <= res_off_r;
          out_tried_r <= res_tried_r;
          out_taken_r <= res_taken_r;
          out_pc_r    <= res_pc_r;
          out_pr_r    <= res_pr_r;
          out_ph_r    <= res_ph_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready        = state_r == ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_walker_col  = out_wc_r;
  assign out_walker_row  = out_wr_r;
  assign out_wall_hit    = out_wall_r;
  assign out_hit_point   = out_hitp_r;
  assign out_off_grid    = out_off_r;
  assign out_tweak_tried = out_tried_r;
  assign out_tweak_taken = out_taken_r;
  assign out_point_col   = out_pc_r;
  assign out_point_row   = out_pr_r;
  assign out_point_hits  = out_ph_r;

endmodule

// ----- tb/sv/random_walk_chain_wall_sim_tb.sv -----
// ----------------------------------------------------------------------------
// random_walk_chain_wall_sim_tb
// Self-checking bench for the wall simulator: a behavioral copy of the walker,
// chain, impact counts and move rules predicts every result; directed rows are
// followed by random walks and reads under several register settings, with
// bursty input, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module random_walk_chain_wall_sim_tb;
  import rwc_pkg::*;

  typedef struct packed {
    logic [X_W-1:0]      wcol;
    logic [Y_W-1:0]      wrow;
    logic                wall;
    logic [PT_AW-1:0]    hitp;
    logic                off;
    logic                tried;
    logic                taken;
    logic [X_W-1:0]      pcol;
    logic [Y_W-1:0]      prow;
    logic [HIT_BITS-1:0] phits;
  } step_res_t;

  typedef struct {
    logic             cmd;
    logic [1:0]       dir;
    logic [PT_AW-1:0] idx;
    logic [2:0]       mv;
    logic             known;
    logic [X_W-1:0]   wcol;
    logic [Y_W-1:0]   wrow;
    logic             off;
  } dir_row_t;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid, in_ready, in_command;
  logic [1:0] in_walk_dir;
  logic [PT_AW-1:0] in_point_index;
  logic [2:0] in_point_move;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [X_W-1:0] out_walker_col, out_point_col;
  logic [Y_W-1:0] out_walker_row, out_point_row;
  logic out_wall_hit, out_off_grid, out_tweak_tried, out_tweak_taken;
  logic [PT_AW-1:0] out_hit_point;
  logic [HIT_BITS-1:0] out_point_hits;

  random_walk_chain_wall_sim uut (.*);

  // predictor state
  int src_x, ctr_off, period;
  int wk_x, wk_y;
  int unsigned phase;
  int pt_x [CHAIN_LEN];
  int pt_y [CHAIN_LEN];
  logic [HIT_BITS-1:0] pt_hits [CHAIN_LEN];
  int owner [CELLS];

  step_res_t expected_results[$];
  int errors = 0, n_results = 0, n_hits = 0, n_tried = 0, n_taken = 0, n_off = 0;
  int cycles = 0;
  logic hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void chain_reset();
    int cx, cy;
    src_x = RESET_SOURCE; ctr_off = RESET_CENTER; period = RESET_PERIOD;
    wk_x = src_x; wk_y = 0; phase = 0;
    foreach (owner[i]) owner[i] = 0;
    cx = RESET_SOURCE - CHAIN_LEN / 4; cy = 0;
    for (int i = 0; i < CHAIN_LEN; i++) begin
      pt_x[i] = cx; pt_y[i] = cy; pt_hits[i] = '0;
      if (cx >= 0 && cx < GRID_W && cy >= 0 && cy < GRID_H) owner[cy * GRID_W + cx] = i + 1;
      if (i >= 3 * CHAIN_LEN / 4 - 2) cy -= 1;
      else if (i > CHAIN_LEN / 4) cx += 1;
      else cy += 1;
    end
  endfunction

  function automatic bit inside_grid(int x, int y);
    return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
  endfunction

  function automatic bit near8(int x, int y, int tx, int ty);
    return (x - tx) >= -1 && (x - tx) <= 1 && (y - ty) >= -1 && (y - ty) <= 1;
  endfunction

  function automatic bit chain_move(int idx, int mv);
    int dxs [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    int dys [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    int ox, oy, nx, ny, rd, lap;
    bit lo, hi, ok;
    logic [HIT_BITS:0] sum, two;
    logic [HIT_BITS-1:0] a, b, h, avg;
    if (idx >= CHAIN_LEN) return 0;
    ox = pt_x[idx]; oy = pt_y[idx];
    nx = ox + dxs[mv]; ny = oy + dys[mv];
    lo = idx > 0; hi = idx < CHAIN_LEN - 1;
    ok = inside_grid(nx, ny) && nx != src_x && ny != 0;
    if (ok) ok = owner[ny * GRID_W + nx] == 0;
    if (ok && lo) ok = near8(nx, ny, pt_x[idx-1], pt_y[idx-1]);
    if (ok && hi) ok = near8(nx, ny, pt_x[idx+1], pt_y[idx+1]);
    if (ok && !lo) ok = ny == oy && nx < src_x;
    if (ok && !hi) ok = ny == oy && nx > src_x;
    if (!ok) return 0;
    rd = (nx - src_x) ** 2 + (ny - ctr_off) ** 2 - (ox - src_x) ** 2 - (oy - ctr_off) ** 2;
    h = pt_hits[idx];
    if (lo && hi) begin
      a = pt_hits[idx-1]; b = pt_hits[idx+1];
      sum = {1'b0, a} + {1'b0, b};
      two = {h, 1'b0};
      lap = two > sum ? 1 : (two < sum ? -1 : 0);
      avg = sum[HIT_BITS:1];
    end else begin
      a = lo ? pt_hits[idx-1] : pt_hits[idx+1];
      lap = h > a ? 1 : (h < a ? -1 : 0);
      avg = a;
    end
    if (!((rd > 0 && lap > 0) || (rd < 0 && lap < 0))) return 0;
    if (inside_grid(ox, oy) && owner[oy * GRID_W + ox] == idx + 1) owner[oy * GRID_W + ox] = 0;
    owner[ny * GRID_W + nx] = idx + 1;
    pt_x[idx] = nx; pt_y[idx] = ny; pt_hits[idx] = avg;
    return 1;
  endfunction

  function automatic step_res_t predict_step(logic cmd, logic [1:0] dir, logic [PT_AW-1:0] idx,
                                             logic [2:0] mv);
    step_res_t r;
    int nx, ny, own, per;
    r = '0;
    if (cmd == CMD_READ) begin
      if (idx < CHAIN_LEN) begin
        r.pcol = X_W'(pt_x[idx]); r.prow = Y_W'(pt_y[idx]); r.phits = pt_hits[idx];
      end
    end else begin
      per = period == 0 ? 1 : period;
      nx = wk_x + (dir == 1 ? 1 : dir == 3 ? -1 : 0);
      ny = wk_y + (dir == 0 ? -1 : dir == 2 ? 1 : 0);
      if (ny < 0) begin
        wk_x = src_x; wk_y = 0;
      end else if (!inside_grid(nx, ny)) begin
        r.off = 1; wk_x = src_x; wk_y = 0;
      end else begin
        own = owner[ny * GRID_W + nx];
        if (own != 0) begin
          if (pt_hits[own-1] != HIT_MAX) pt_hits[own-1]++;
          r.wall = 1; r.hitp = PT_AW'(own - 1);
          wk_x = src_x; wk_y = 0;
        end else begin
          wk_x = nx; wk_y = ny;
        end
      end
      if (phase >= per) begin
        r.tried = 1;
        r.taken = chain_move(idx, mv);
        wk_x = src_x; wk_y = 0;
        phase = 1;
      end else begin
        phase++;
      end
    end
    r.wcol = X_W'(wk_x); r.wrow = Y_W'(wk_y);
    return r;
  endfunction

  task automatic reg_write(logic [1:0] regno, int value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(regno) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (regno)
      REG_SOURCE: src_x = value & 'h7f;
      REG_CENTER: ctr_off = value & 'h3f;
      default: period = value & 'hfffff;
    endcase
    @(posedge clk);
  endtask

  task automatic send_step(logic cmd, logic [1:0] dir, logic [PT_AW-1:0] idx, logic [2:0] mv);
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_command <= cmd; in_walk_dir <= dir;
    in_point_index <= idx; in_point_move <= mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_step(cmd, dir, idx, mv));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!hold_off) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 0;
    if (out_valid && out_ready && rst_n) begin
      step_res_t e;
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_wall_hit) n_hits++;
        if (out_tweak_tried) n_tried++;
        if (out_tweak_taken) n_taken++;
        if (out_off_grid) n_off++;
        if (e.wcol != out_walker_col) begin
          $error("walker_col exp %0d got %0d", e.wcol, out_walker_col); errors++;
        end
        if (e.wrow != out_walker_row) begin
          $error("walker_row exp %0d got %0d", e.wrow, out_walker_row); errors++;
        end
        if (e.wall != out_wall_hit) begin
          $error("wall_hit exp %0d got %0d", e.wall, out_wall_hit); errors++;
        end
        if (e.hitp != out_hit_point) begin
          $error("hit_point exp %0d got %0d", e.hitp, out_hit_point); errors++;
        end
        if (e.off != out_off_grid) begin
          $error("off_grid exp %0d got %0d", e.off, out_off_grid); errors++;
        end
        if (e.tried != out_tweak_tried) begin
          $error("tweak_tried exp %0d got %0d", e.tried, out_tweak_tried); errors++;
        end
        if (e.taken != out_tweak_taken) begin
          $error("tweak_taken exp %0d got %0d", e.taken, out_tweak_taken); errors++;
        end
        if (e.pcol != out_point_col) begin
          $error("point_col exp %0d got %0d", e.pcol, out_point_col); errors++;
        end
        if (e.prow != out_point_row) begin
          $error("point_row exp %0d got %0d", e.prow, out_point_row); errors++;
        end
        if (e.phits != out_point_hits) begin
          $error("point_hits exp %0d got %0d", e.phits, out_point_hits); errors++;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (n_results == 400);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
  end

  dir_row_t dir_rows [] = '{
    '{CMD_WALK, 2'd0, 7'd0, 3'd0, 1, 7'd50, 6'd0, 0},    // north from row zero -> home
    '{CMD_WALK, 2'd2, 7'd0, 3'd0, 1, 7'd50, 6'd1, 0},
    '{CMD_WALK, 2'd1, 7'd0, 3'd0, 1, 7'd51, 6'd1, 0},
    '{CMD_WALK, 2'd3, 7'd0, 3'd0, 1, 7'd50, 6'd1, 0},
    '{CMD_WALK, 2'd0, 7'd0, 3'd0, 1, 7'd50, 6'd0, 0},
    '{CMD_READ, 2'd0, 7'd0, 3'd0, 0, 0, 0, 0},
    '{CMD_READ, 2'd3, 7'd99, 3'd7, 0, 0, 0, 0},
    '{CMD_READ, 2'd0, 7'd127, 3'd0, 0, 0, 0, 0},          // out of range read
    '{CMD_READ, 2'd0, 7'd50, 3'd0, 0, 0, 0, 0}
  };

  int nsteps;
  logic [1:0] d;

  initial begin
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_command = 0; in_walk_dir = 0; in_point_index = 0; in_point_move = 0;
    chain_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_step(dir_rows[i].cmd, dir_rows[i].dir, dir_rows[i].idx, dir_rows[i].mv);
      if (dir_rows[i].known) begin
        if (expected_results[$].wcol != dir_rows[i].wcol ||
            expected_results[$].wrow != dir_rows[i].wrow ||
            expected_results[$].off != dir_rows[i].off) begin
          $error("directed row %0d disagrees with predictor", i); errors++;
        end
      end
    end
    // west into the left chain column, then south into the bottom wall
    for (int i = 0; i < 60; i++) send_step(CMD_WALK, 2'd3, 7'd0, 3'd0);
    for (int i = 0; i < 45; i++) send_step(CMD_WALK, 2'd2, 7'd0, 3'd0);
    drain();
    // several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(REG_PERIOD, 1); reg_write(REG_CENTER, 39); end
        1: begin reg_write(REG_PERIOD, 0); reg_write(REG_CENTER, 0); end
        2: begin reg_write(REG_PERIOD, 3); reg_write(REG_SOURCE, 99); end
        3: begin reg_write(REG_SOURCE, 0); reg_write(REG_PERIOD, 'hfffff); end
        4: begin reg_write(REG_SOURCE, 127); reg_write(REG_PERIOD, 2); end
        default: begin
          reg_write(REG_SOURCE, 50); reg_write(REG_CENTER, 10); reg_write(REG_PERIOD, 5);
        end
      endcase
      nsteps = (ph == 4) ? 20 : 200;
      for (int i = 0; i < nsteps; i++) begin
        d = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 6) d = 2'd2;  // bias downward to reach the wall
        send_step($urandom_range(0, 7) == 0, d,
                  PT_AW'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) :
                                                     $urandom_range(0, 99)),
                  3'($urandom_range(0, 7)));
      end
      drain();
    end
    $display("covered %0d results: %0d wall hits, %0d off grid, %0d move attempts, %0d taken",
             n_results, n_hits, n_off, n_tried, n_taken);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
